// ===== rtl/amdtp_pkg.sv =====
// Shared types, constants and rate tables for the AMDTP transmit packet pacer.
package amdtp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DBS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd4;

  // item actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_CYCLE = 1'b1;

  // rate codes
  localparam logic [2:0] RATE_32K   = 3'd0;
  localparam logic [2:0] RATE_44K1  = 3'd1;
  localparam logic [2:0] RATE_48K   = 3'd2;
  localparam logic [2:0] RATE_88K2  = 3'd3;
  localparam logic [2:0] RATE_96K   = 3'd4;
  localparam logic [2:0] RATE_176K4 = 3'd5;
  localparam logic [2:0] RATE_192K  = 3'd6;

  localparam logic [12:0] CYCLE_TICKS     = 13'd3072;
  localparam logic [10:0] TICKS_44K1      = 11'd1386;
  localparam logic [12:0] SYT_PERIOD      = 13'd147;
  localparam logic [11:0] SYT_PHASE_LAST  = 12'd146;
  localparam logic [6:0]  BLOCK_PERIOD    = 7'd80;
  localparam logic [6:0]  BLOCK_SPLIT     = 7'd40;
  localparam logic [5:0]  MAX_BLOCKS      = 6'd32;
  localparam logic [15:0] SYT_NO_INFO     = 16'hffff;
  localparam logic [7:0]  CIP_FMT_BYTE    = 8'h90;
  localparam logic [14:0] CIP_HDR_BYTES   = 15'd8;

  typedef struct packed {
    logic [2:0]  rate_code;
    logic        blocking_mode;
    logic [7:0]  block_quadlets;
    logic [5:0]  node_id;
    logic [14:0] xmit_delay;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [12:0] cycle;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  block_count;
    logic [15:0] syt;
    logic [31:0] header_first;
    logic [31:0] header_second;
    logic [14:0] payload_bytes;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       step;
    logic [2:0] rate;
  } step_ctl_t;

  function automatic logic [2:0] eff_rate(input logic [2:0] code);
    eff_rate = (code > RATE_192K) ? RATE_192K : code;
  endfunction

  function automatic logic [6:0] init_blocks(input logic [2:0] rate);
    case (rate)
      RATE_32K:  init_blocks = 7'd4;
      RATE_48K:  init_blocks = 7'd6;
      RATE_96K:  init_blocks = 7'd12;
      RATE_192K: init_blocks = 7'd24;
      default:   init_blocks = 7'd0;
    endcase
  endfunction

  function automatic logic [11:0] init_offset(input logic [2:0] rate);
    case (rate)
      RATE_32K:   init_offset = 12'd3072;
      RATE_44K1,
      RATE_88K2,
      RATE_176K4: init_offset = 12'd67;
      default:    init_offset = 12'd1024;
    endcase
  endfunction

  function automatic logic [5:0] stamp_blocks(input logic [2:0] rate);
    case (rate)
      RATE_32K, RATE_44K1, RATE_48K: stamp_blocks = 6'd8;
      RATE_88K2, RATE_96K:           stamp_blocks = 6'd16;
      default:                       stamp_blocks = 6'd32;
    endcase
  endfunction

  // v mod 13 via reciprocal 5042/2^16, exact for 12-bit v
  function automatic logic [3:0] mod13(input logic [11:0] v);
    logic [24:0] prod;
    logic [8:0]  q;
    logic [12:0] qx13;
    logic [12:0] diff;
    prod  = {13'd0, v} * 25'd5042;
    q     = prod[24:16];
    qx13  = 13'({4'd0, q} * 13'd13);
    diff  = {1'b0, v} - qx13;
    mod13 = diff[3:0];
  endfunction

  // x / 3 via 43/128, exact for 6-bit x
  function automatic logic [4:0] div3(input logic [5:0] x);
    logic [12:0] prod;
    prod = {7'd0, x} * 13'd43;
    div3 = prod[11:7];
  endfunction

endpackage

// ===== rtl/amdtp_cfg_regs.sv =====
// Configuration register file of the packet pacer.
module amdtp_cfg_regs import amdtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_code      <= RATE_48K;
      cfg.blocking_mode  <= 1'b0;
      cfg.block_quadlets <= 8'd2;
      cfg.node_id        <= 6'd0;
      cfg.xmit_delay     <= 15'd8704;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE:     cfg.rate_code      <= cfg_data[2:0];
        REG_BLOCKING: cfg.blocking_mode  <= cfg_data[0];
        REG_DBS:      cfg.block_quadlets <= cfg_data[7:0];
        REG_NODE:     cfg.node_id        <= cfg_data[5:0];
        REG_DELAY:    cfg.xmit_delay     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/amdtp_syt_gen.sv =====
// SYT offset accumulator and timestamp formation.
module amdtp_syt_gen import amdtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  step_ctl_t   ctl,
  input  logic [14:0] delay,
  input  logic [3:0]  cycle_lo,
  output logic [15:0] syt,
  output logic        syt_valid
);

  logic [11:0] offset_phase;
  logic [12:0] last_offset;

  logic [3:0]  idx;
  logic        extra;
  logic [12:0] phase_inc;
  logic [11:0] phase_next;
  logic        pending;
  logic [12:0] off;
  logic [15:0] t;
  logic [5:0]  t_hi;
  logic [4:0]  q;
  logic [5:0]  rem;

  always_comb begin
    idx        = mod13(offset_phase);
    extra      = ((idx != 4'd0) && (idx[1:0] == 2'b00)) || (offset_phase == SYT_PHASE_LAST);
    phase_inc  = {1'b0, offset_phase} + 13'd1;
    phase_next = (phase_inc >= SYT_PERIOD) ? 12'd0 : phase_inc[11:0];
    pending    = last_offset < CYCLE_TICKS;

    if (pending) begin
      if (!ctl.rate[0]) begin
        off = last_offset + {1'b0, offset_phase};
      end else begin
        off = last_offset + {2'b00, TICKS_44K1} + {12'd0, extra};
      end
    end else begin
      off = last_offset - CYCLE_TICKS;
    end
    syt_valid = off < CYCLE_TICKS;

    // split t into whole cycles and ticks: 3072 = 3 * 1024
    t    = {3'd0, off} + {1'b0, delay};
    t_hi = t[15:10];
    q    = div3(t_hi);
    rem  = t_hi - {q, 1'b0} - {1'b0, q};
    syt  = syt_valid ? {cycle_lo + q[3:0], rem[1:0], t[9:0]} : SYT_NO_INFO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_phase <= 12'd0;
      last_offset  <= CYCLE_TICKS;
    end else if (ctl.start) begin
      offset_phase <= init_offset(ctl.rate);
      last_offset  <= CYCLE_TICKS;
    end else if (ctl.step) begin
      last_offset <= off;
      if (pending && ctl.rate[0]) begin
        offset_phase <= phase_next;
      end
    end
  end

  // a no-info cycle only drains one cycle's worth of ticks
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && !ctl.start && !pending) |=> last_offset == $past(last_offset) - CYCLE_TICKS)
    else $error("offset drain mismatch");

endmodule

// ===== rtl/amdtp_blk_gen.sv =====
// Data block count per packet and data block counter.
module amdtp_blk_gen import amdtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  step_ctl_t  ctl,
  input  logic       blocking,
  input  logic       syt_valid,
  output logic [5:0] blocks,
  output logic [7:0] dbc
);

  logic [6:0] block_phase;

  logic       advance;
  logic [6:0] limit;
  logic [7:0] ph_inc;
  logic [6:0] ph_next;

  always_comb begin
    advance = 1'b0;
    limit   = BLOCK_PERIOD >> ctl.rate[2:1];
    ph_inc  = {1'b0, block_phase} + 8'd1;
    ph_next = (ph_inc >= {1'b0, limit}) ? 7'd0 : ph_inc[6:0];

    if (blocking) begin
      blocks = syt_valid ? stamp_blocks(ctl.rate) : 6'd0;
    end else if (!ctl.rate[0]) begin
      blocks = (block_phase > {1'b0, MAX_BLOCKS}) ? MAX_BLOCKS : block_phase[5:0];
    end else begin
      advance = 1'b1;
      if (ctl.rate == RATE_44K1) begin
        // 6/5 pattern, inverted over the second half of the period
        blocks = 6'd5 + {5'd0, block_phase[0] ^
                         ((block_phase == 7'd0) || (block_phase >= BLOCK_SPLIT))};
      end else begin
        blocks = 6'({4'd0, ctl.rate[2:1]} * 6'd11) + {5'd0, block_phase == 7'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_phase <= 7'd0;
      dbc         <= 8'd0;
    end else if (ctl.start) begin
      block_phase <= init_blocks(ctl.rate);
      dbc         <= 8'd0;
    end else if (ctl.step) begin
      if (advance) begin
        block_phase <= ph_next;
      end
      dbc <= dbc + {2'b00, blocks};
    end
  end

  a_max_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> blocks <= MAX_BLOCKS)
    else $error("block count above 32");

endmodule

// ===== rtl/amdtp_tx_packet_pacer.sv =====
// Top level of the AMDTP transmit packet pacer: input register, packet units, result register.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   item     | item_valid / item_ready     | in_item_t  (action, cycle)
//   result   | result_valid / result_ready | out_item_t (count, syt, headers, len)
//   config   | cfg_we, cfg_index           | cfg_data, 15 bits, write only
//
// One item per clock unless stalled; a cycle item passes the input, then the result register.
// A start item passes through the input register and returns no result.
// The input register holds a cycle item while the result register is full and not taken.
// Reset is synchronous: 48 kHz defaults, offset 3072, all phases and the counter at zero.
module amdtp_tx_packet_pacer import amdtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       s0_valid;
  in_item_t   s0_q;
  logic       s0_go;
  step_ctl_t  ctl;
  logic [15:0] syt;
  logic        syt_valid;
  logic [5:0]  blocks;
  logic [7:0]  dbc;
  logic [12:0] blk_quads;
  out_item_t   res_next;

  amdtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s0_go = s0_valid && ((s0_q.action == ACT_START) || !result_valid || result_ready);
  assign item_ready = !s0_valid || s0_go;

  always_comb begin
    ctl.start = s0_go && (s0_q.action == ACT_START);
    ctl.step  = s0_go && (s0_q.action == ACT_CYCLE);
    ctl.rate  = eff_rate(cfg.rate_code);
  end

  amdtp_syt_gen u_syt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .delay     (cfg.xmit_delay),
    .cycle_lo  (s0_q.cycle[3:0]),
    .syt       (syt),
    .syt_valid (syt_valid)
  );

  amdtp_blk_gen u_blk (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .blocking  (cfg.blocking_mode),
    .syt_valid (syt_valid),
    .blocks    (blocks),
    .dbc       (dbc)
  );

  always_comb begin
    blk_quads                = 13'({7'd0, blocks} * {5'd0, cfg.block_quadlets});
    res_next.block_count     = blocks;
    res_next.syt             = syt;
    res_next.header_first    = {2'b00, cfg.node_id, cfg.block_quadlets, 8'd0, dbc};
    res_next.header_second   = {CIP_FMT_BYTE, 5'd0, ctl.rate, syt};
    res_next.payload_bytes   = CIP_HDR_BYTES + {blk_quads, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_ready) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s0_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      result <= res_next;
    end
  end

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s0_valid && (s0_q.action == ACT_CYCLE)))
    else $error("result without a cycle transaction");

  a_s0_hold: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && !s0_go) |=> (s0_valid && $stable(s0_q)))
    else $error("input register lost a stalled transaction");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.payload_bytes ==
      CIP_HDR_BYTES + {13'({7'd0, result.block_count} * {5'd0, result.header_first[23:16]}),
                       2'b00})
    else $error("payload length does not match block count");

endmodule
